// ===== sv/clock_calendar_setter_macros.svh =====
// Assertion helpers used by the checker in sv/ccs_checker.sv.
`ifndef CLOCK_CALENDAR_SETTER_MACROS_SVH
`define CLOCK_CALENDAR_SETTER_MACROS_SVH

// Concurrent check, switched off while reset is asserted
`define CCS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent check that also holds during reset
`define CCS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/ccs_pkg.sv =====
package ccs_pkg;

  // Field widths
  localparam int unsigned CmdW   = 2;
  localparam int unsigned ModeW  = 4;
  localparam int unsigned HourW  = 5;
  localparam int unsigned MinW   = 6;
  localparam int unsigned SecW   = 6;
  localparam int unsigned DayW   = 5;
  localparam int unsigned MonW   = 4;
  localparam int unsigned YearW  = 7;
  localparam int unsigned CountW = 8;
  // working width for edits: holds -1 .. 128
  localparam int unsigned WorkW  = 9;

  // Commands
  typedef enum logic [CmdW-1:0] {
    CMD_MODE   = 2'd0,
    CMD_UP     = 2'd1,
    CMD_DOWN   = 2'd2,
    CMD_SAMPLE = 2'd3
  } ccs_cmd_e;

  // Edit mode codes
  localparam logic [ModeW-1:0] MODE_RUN    = 4'd0;
  localparam logic [ModeW-1:0] MODE_HOUR   = 4'd1;
  localparam logic [ModeW-1:0] MODE_MINUTE = 4'd2;
  localparam logic [ModeW-1:0] MODE_SECOND = 4'd3;
  localparam logic [ModeW-1:0] MODE_DAY    = 4'd4;
  localparam logic [ModeW-1:0] MODE_MONTH  = 4'd5;
  localparam logic [ModeW-1:0] MODE_YEAR   = 4'd6;
  localparam logic [ModeW-1:0] MODE_AHOUR  = 4'd7;
  localparam logic [ModeW-1:0] MODE_AMIN   = 4'd8;

  // Month numbers with short lengths
  localparam logic signed [WorkW-1:0] MonFeb = 9'sd2;
  localparam logic signed [WorkW-1:0] MonApr = 9'sd4;
  localparam logic signed [WorkW-1:0] MonJun = 9'sd6;
  localparam logic signed [WorkW-1:0] MonSep = 9'sd9;
  localparam logic signed [WorkW-1:0] MonNov = 9'sd11;

  localparam logic [CountW-1:0] CountMax = '1;
  localparam logic [SecW-1:0]   AlarmSecs = 6'd10;

  // One input transaction
  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [HourW-1:0] rtc_hour;
    logic [MinW-1:0]  rtc_minute;
    logic [SecW-1:0]  rtc_second;
    logic [DayW-1:0]  rtc_day;
    logic [MonW-1:0]  rtc_month;
    logic [YearW-1:0] rtc_year;
  } ccs_item_t;

  // Held time, date and alarm
  typedef struct packed {
    logic [HourW-1:0] hour;
    logic [MinW-1:0]  minute;
    logic [SecW-1:0]  second;
    logic [DayW-1:0]  day;
    logic [MonW-1:0]  month;
    logic [YearW-1:0] year;
    logic [HourW-1:0] alarm_hour;
    logic [MinW-1:0]  alarm_minute;
  } ccs_time_t;

  typedef struct packed {
    logic [ModeW-1:0]  mode;
    ccs_time_t         tm;
    logic [SecW-1:0]   last_second;
    logic [CountW-1:0] same_count;
  } ccs_state_t;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    ccs_time_t        tm;
    logic             write_back;
    logic             beep;
  } ccs_result_t;

  // Wrap only the two values just outside the range
  function automatic logic signed [WorkW-1:0] wrap_field(
    input logic signed [WorkW-1:0] v,
    input logic signed [WorkW-1:0] lo,
    input logic signed [WorkW-1:0] hi
  );
    logic signed [WorkW-1:0] r;
    r = v;
    if (v == hi + 9'sd1) begin
      r = lo;
    end else if (v == lo - 9'sd1) begin
      r = hi;
    end
    return r;
  endfunction

  // Days in month; leap year every fourth year
  function automatic logic signed [WorkW-1:0] month_length(
    input logic signed [WorkW-1:0] m,
    input logic signed [WorkW-1:0] y
  );
    logic signed [WorkW-1:0] len;
    len = 9'sd31;
    if (m == MonFeb) begin
      len = (y[1:0] == 2'b00) ? 9'sd29 : 9'sd28;
    end else if (m == MonApr || m == MonJun || m == MonSep || m == MonNov) begin
      len = 9'sd30;
    end
    return len;
  endfunction

endpackage

// ===== sv/ccs_if.sv =====
// Input channel: one command per transaction
interface ccs_in_if;
  logic                         valid;
  logic                         ready;
  logic [ccs_pkg::CmdW-1:0]     cmd;
  logic [ccs_pkg::HourW-1:0]    rtc_hour;
  logic [ccs_pkg::MinW-1:0]     rtc_minute;
  logic [ccs_pkg::SecW-1:0]     rtc_second;
  logic [ccs_pkg::DayW-1:0]     rtc_day;
  logic [ccs_pkg::MonW-1:0]     rtc_month;
  logic [ccs_pkg::YearW-1:0]    rtc_year;

  modport source (
    output valid, cmd, rtc_hour, rtc_minute, rtc_second, rtc_day, rtc_month, rtc_year,
    input  ready
  );
  modport sink (
    input  valid, cmd, rtc_hour, rtc_minute, rtc_second, rtc_day, rtc_month, rtc_year,
    output ready
  );
endinterface

// Output channel: held values after each command
interface ccs_out_if;
  logic                         valid;
  logic                         ready;
  logic [ccs_pkg::ModeW-1:0]    edit_mode;
  logic [ccs_pkg::HourW-1:0]    hour_out;
  logic [ccs_pkg::MinW-1:0]     minute_out;
  logic [ccs_pkg::SecW-1:0]     second_out;
  logic [ccs_pkg::DayW-1:0]     day_out;
  logic [ccs_pkg::MonW-1:0]     month_out;
  logic [ccs_pkg::YearW-1:0]    year_out;
  logic [ccs_pkg::HourW-1:0]    alarm_hour_out;
  logic [ccs_pkg::MinW-1:0]     alarm_minute_out;
  logic                         write_back;
  logic                         beep;

  modport source (
    output valid, edit_mode, hour_out, minute_out, second_out, day_out, month_out,
           year_out, alarm_hour_out, alarm_minute_out, write_back, beep,
    input  ready
  );
  modport sink (
    input  valid, edit_mode, hour_out, minute_out, second_out, day_out, month_out,
           year_out, alarm_hour_out, alarm_minute_out, write_back, beep,
    output ready
  );
endinterface

// ===== sv/ccs_edit.sv =====
// Up/down edit of the selected field, then repair of every field
module ccs_edit (
  input  ccs_pkg::ccs_time_t        tm_i,
  input  logic [ccs_pkg::ModeW-1:0] mode_i,
  input  logic                      up_i,
  output ccs_pkg::ccs_time_t        tm_o
);

  logic signed [ccs_pkg::WorkW-1:0] delta;
  logic signed [ccs_pkg::WorkW-1:0] h, mi, s, d, mo, y, ah, am;
  logic signed [ccs_pkg::WorkW-1:0] len;

  assign delta = up_i ? 9'sd1 : -9'sd1;

  always_comb begin
    // widen without sign so that one step below zero reads as -1
    h  = signed'(9'(tm_i.hour));
    mi = signed'(9'(tm_i.minute));
    s  = signed'(9'(tm_i.second));
    d  = signed'(9'(tm_i.day));
    mo = signed'(9'(tm_i.month));
    y  = signed'(9'(tm_i.year));
    ah = signed'(9'(tm_i.alarm_hour));
    am = signed'(9'(tm_i.alarm_minute));

    case (mode_i)
      ccs_pkg::MODE_HOUR:   h  = h + delta;
      ccs_pkg::MODE_MINUTE: mi = mi + delta;
      ccs_pkg::MODE_SECOND: s  = s + delta;
      ccs_pkg::MODE_DAY:    d  = d + delta;
      ccs_pkg::MODE_MONTH:  mo = mo + delta;
      ccs_pkg::MODE_YEAR:   y  = y + delta;
      ccs_pkg::MODE_AHOUR:  ah = ah + delta;
      ccs_pkg::MODE_AMIN:   am = am + delta;
      default: ;
    endcase

    s  = ccs_pkg::wrap_field(s,  9'sd0, 9'sd59);
    mi = ccs_pkg::wrap_field(mi, 9'sd0, 9'sd59);
    h  = ccs_pkg::wrap_field(h,  9'sd0, 9'sd23);
    mo = ccs_pkg::wrap_field(mo, 9'sd1, 9'sd12);
    y  = ccs_pkg::wrap_field(y,  9'sd0, 9'sd99);

    // day depends on the repaired month and year
    len = ccs_pkg::month_length(mo, y);
    if (d == 9'sd0) begin
      d = len;
    end else if (d == len + 9'sd1) begin
      d = 9'sd1;
    end

    am = ccs_pkg::wrap_field(am, 9'sd0, 9'sd59);
    ah = ccs_pkg::wrap_field(ah, 9'sd0, 9'sd23);

    tm_o.hour         = h[ccs_pkg::HourW-1:0];
    tm_o.minute       = mi[ccs_pkg::MinW-1:0];
    tm_o.second       = s[ccs_pkg::SecW-1:0];
    tm_o.day          = d[ccs_pkg::DayW-1:0];
    tm_o.month        = mo[ccs_pkg::MonW-1:0];
    tm_o.year         = y[ccs_pkg::YearW-1:0];
    tm_o.alarm_hour   = ah[ccs_pkg::HourW-1:0];
    tm_o.alarm_minute = am[ccs_pkg::MinW-1:0];
  end

endmodule

// ===== sv/ccs_datapath.sv =====
// Next state and result for one command
module ccs_datapath (
  input  ccs_pkg::ccs_state_t  state_i,
  input  ccs_pkg::ccs_item_t   item_i,
  output ccs_pkg::ccs_state_t  state_o,
  output ccs_pkg::ccs_result_t res_o
);

  ccs_pkg::ccs_time_t edit_tm;
  ccs_pkg::ccs_cmd_e  cmd;
  logic               wb, bp;
  logic               alarm_hit, chime_hit;

  assign cmd = ccs_pkg::ccs_cmd_e'(item_i.cmd);

  ccs_edit u_edit (
    .tm_i   (state_i.tm),
    .mode_i (state_i.mode),
    .up_i   (cmd == ccs_pkg::CMD_UP),
    .tm_o   (edit_tm)
  );

  always_comb begin
    state_o   = state_i;
    wb        = 1'b0;
    bp        = 1'b0;
    alarm_hit = 1'b0;
    chime_hit = 1'b0;
    case (cmd)
      ccs_pkg::CMD_MODE: begin
        state_o.mode = (state_i.mode == ccs_pkg::MODE_AMIN) ? ccs_pkg::MODE_RUN
                                                             : state_i.mode + 4'd1;
        bp = 1'b1;
      end
      ccs_pkg::CMD_UP, ccs_pkg::CMD_DOWN: begin
        if (state_i.mode != ccs_pkg::MODE_RUN) begin
          state_o.tm = edit_tm;
          bp = 1'b1;
          wb = 1'b1;
        end
      end
      ccs_pkg::CMD_SAMPLE: begin
        if (state_i.mode == ccs_pkg::MODE_RUN) begin
          state_o.tm.hour   = item_i.rtc_hour;
          state_o.tm.minute = item_i.rtc_minute;
          state_o.tm.second = item_i.rtc_second;
          state_o.tm.day    = item_i.rtc_day;
          state_o.tm.month  = item_i.rtc_month;
          state_o.tm.year   = item_i.rtc_year;
          // count repeated samples of the same second
          if (state_i.last_second != item_i.rtc_second) begin
            state_o.last_second = item_i.rtc_second;
            state_o.same_count  = '0;
          end else if (state_i.same_count != ccs_pkg::CountMax) begin
            state_o.same_count = state_i.same_count + 8'd1;
          end
          alarm_hit = (item_i.rtc_hour == state_i.tm.alarm_hour) &&
                      (item_i.rtc_minute == state_i.tm.alarm_minute) &&
                      (item_i.rtc_second < ccs_pkg::AlarmSecs);
          chime_hit = (item_i.rtc_minute == '0) && (item_i.rtc_second == '0) &&
                      ((state_o.same_count == 8'd0) || (state_o.same_count == 8'd4));
          bp = alarm_hit || chime_hit;
        end
      end
      default: ;
    endcase
  end

  assign res_o.mode       = state_o.mode;
  assign res_o.tm         = state_o.tm;
  assign res_o.write_back = wb;
  assign res_o.beep       = bp;

endmodule

// ===== sv/clock_calendar_setter.sv =====
// Clock and calendar editor with alarm and hourly chime.
// in_i  : valid/ready channel; each transaction is a command (mode press, up,
//         down, or a clock sample carrying hour..year).
// out_o : valid/ready channel; one transaction per command, carrying the edit
//         mode, all held time/date/alarm fields, a write-back flag and a beep.
// A command taken into the input register moves on into the result register
// once that register is empty or its result is being taken.
// Throughput: one command per cycle while out_o is not stalled; the only loop
// is the state update from the input register into the held-field registers.
// Stall: while a result waits the input register can still take one command;
// with both registers full in_i.ready drops until out_o is taken.
// Reset: both channels empty, run mode, time 00:00:00, day 1, month 1,
// year 0, alarm 00:00, repeat-second counter cleared.
module clock_calendar_setter (
  input  logic             clk_i,
  input  logic             rst_ni,
  ccs_in_if.sink           in_i,
  ccs_out_if.source        out_o
);

  logic                 in_vld_q, out_vld_q;
  ccs_pkg::ccs_item_t   item_q;
  ccs_pkg::ccs_state_t  state_q, state_d;
  ccs_pkg::ccs_result_t res_q, res_d;
  logic                 advance, fire, in_acc;

  // Handshake control
  assign advance    = !out_vld_q || out_o.ready;
  assign fire       = in_vld_q && advance;
  assign in_i.ready = !in_vld_q || advance;
  assign in_acc     = in_i.valid && in_i.ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_acc) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q.cmd        <= in_i.cmd;
      item_q.rtc_hour   <= in_i.rtc_hour;
      item_q.rtc_minute <= in_i.rtc_minute;
      item_q.rtc_second <= in_i.rtc_second;
      item_q.rtc_day    <= in_i.rtc_day;
      item_q.rtc_month  <= in_i.rtc_month;
      item_q.rtc_year   <= in_i.rtc_year;
    end
  end

  ccs_datapath u_datapath (
    .state_i (state_q),
    .item_i  (item_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  // Held state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode            <= ccs_pkg::MODE_RUN;
      state_q.tm.hour         <= '0;
      state_q.tm.minute       <= '0;
      state_q.tm.second       <= '0;
      state_q.tm.day          <= 5'd1;
      state_q.tm.month        <= 4'd1;
      state_q.tm.year         <= '0;
      state_q.tm.alarm_hour   <= '0;
      state_q.tm.alarm_minute <= '0;
      state_q.last_second     <= '0;
      state_q.same_count      <= '0;
    end else if (fire) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid            = out_vld_q;
  assign out_o.edit_mode        = res_q.mode;
  assign out_o.hour_out         = res_q.tm.hour;
  assign out_o.minute_out       = res_q.tm.minute;
  assign out_o.second_out       = res_q.tm.second;
  assign out_o.day_out          = res_q.tm.day;
  assign out_o.month_out        = res_q.tm.month;
  assign out_o.year_out         = res_q.tm.year;
  assign out_o.alarm_hour_out   = res_q.tm.alarm_hour;
  assign out_o.alarm_minute_out = res_q.tm.alarm_minute;
  assign out_o.write_back       = res_q.write_back;
  assign out_o.beep             = res_q.beep;

endmodule

// ===== sv/ccs_checker.sv =====
`include "clock_calendar_setter_macros.svh"

// Port-level checks on the clock calendar setter
module ccs_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic [ccs_pkg::CmdW-1:0]  in_cmd_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [ccs_pkg::ModeW-1:0] out_edit_mode_i,
  input logic                      out_write_back_i,
  input logic                      out_beep_i
);

  // a stalled result holds
  `CCS_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_edit_mode_i) && $stable(out_write_back_i) && $stable(out_beep_i), "stalled result changed")

  // write-back only comes from an edit, which always beeps
  `CCS_ASSERT(a_wb_edit, clk_i, rst_ni, out_valid_i && out_write_back_i |-> out_beep_i && (out_edit_mode_i != ccs_pkg::MODE_RUN), "write-back outside an edit")

  // input is held off only when both registers are full and the output stalls
  `CCS_ASSERT_ALWAYS(a_backpressure, clk_i, !in_ready_i |-> out_valid_i && !out_ready_i, "input stalled without output stall")

  // a mode press reaches the output with a beep once the result register can take it
  `CCS_ASSERT(a_mode_beep, clk_i, rst_ni, (in_valid_i && in_ready_i && (in_cmd_i == ccs_pkg::CMD_MODE)) ##1 (!out_valid_i || out_ready_i) |=> out_valid_i && out_beep_i, "mode press lost its beep")

endmodule

bind clock_calendar_setter ccs_checker u_ccs_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .in_cmd_i         (in_i.cmd),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_edit_mode_i  (out_o.edit_mode),
  .out_write_back_i (out_o.write_back),
  .out_beep_i       (out_o.beep)
);

// ===== dv/clock_calendar_setter_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels of the clock/calendar editor, keeps its own copy of
// the held fields and compares every result transaction in order.
module clock_calendar_setter_checker
  import ccs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  ccs_in_if    in_i,
  ccs_out_if   out_i,
  output int   errors_o,
  output int   pending_o,
  output int   results_o,
  output int   beeps_o,
  output int   write_backs_o
);

  ccs_state_t  held;
  ccs_result_t predicted_readout_q[$];
  int          errors      = 0;
  int          pending     = 0;
  int          results     = 0;
  int          beeps       = 0;
  int          write_backs = 0;

  assign errors_o      = errors;
  assign pending_o     = pending;
  assign results_o     = results;
  assign beeps_o       = beeps;
  assign write_backs_o = write_backs;

  // Only the values one step outside the range are folded back
  function automatic int wrap_by_one(int v, int lo, int hi);
    if (v == hi + 1) return lo;
    if (v == lo - 1) return hi;
    return v;
  endfunction

  function automatic int days_in_month(int m, int y);
    if (m == MonFeb) return (y % 4 == 0) ? 29 : 28;
    if (m == MonApr || m == MonJun || m == MonSep || m == MonNov) return 30;
    return 31;
  endfunction

  // Apply one command to the held state and return the readout it causes
  function automatic ccs_result_t step_calendar(ccs_item_t it);
    ccs_result_t r;
    int h, mi, s, d, mo, y, ah, am, len, delta;
    r.write_back = 1'b0;
    r.beep       = 1'b0;
    case (it.cmd)
      CMD_MODE: begin
        held.mode = (held.mode == MODE_AMIN) ? MODE_RUN : held.mode + 4'd1;
        r.beep    = 1'b1;
      end
      CMD_UP, CMD_DOWN: begin
        if (held.mode != MODE_RUN) begin
          delta = (it.cmd == CMD_UP) ? 1 : -1;
          h  = held.tm.hour;
          mi = held.tm.minute;
          s  = held.tm.second;
          d  = held.tm.day;
          mo = held.tm.month;
          y  = held.tm.year;
          ah = held.tm.alarm_hour;
          am = held.tm.alarm_minute;
          case (held.mode)
            MODE_HOUR:   h  += delta;
            MODE_MINUTE: mi += delta;
            MODE_SECOND: s  += delta;
            MODE_DAY:    d  += delta;
            MODE_MONTH:  mo += delta;
            MODE_YEAR:   y  += delta;
            MODE_AHOUR:  ah += delta;
            MODE_AMIN:   am += delta;
            default: ;
          endcase
          // every field is repaired, not only the edited one
          s  = wrap_by_one(s, 0, 59);
          mi = wrap_by_one(mi, 0, 59);
          h  = wrap_by_one(h, 0, 23);
          mo = wrap_by_one(mo, 1, 12);
          y  = wrap_by_one(y, 0, 99);
          len = days_in_month(mo, y);
          if (d == 0) begin
            d = len;
          end else if (d == len + 1) begin
            d = 1;
          end
          am = wrap_by_one(am, 0, 59);
          ah = wrap_by_one(ah, 0, 23);
          held.tm.hour         = h[HourW-1:0];
          held.tm.minute       = mi[MinW-1:0];
          held.tm.second       = s[SecW-1:0];
          held.tm.day          = d[DayW-1:0];
          held.tm.month        = mo[MonW-1:0];
          held.tm.year         = y[YearW-1:0];
          held.tm.alarm_hour   = ah[HourW-1:0];
          held.tm.alarm_minute = am[MinW-1:0];
          r.beep       = 1'b1;
          r.write_back = 1'b1;
        end
      end
      default: begin
        // clock sample, taken in run mode only
        if (held.mode == MODE_RUN) begin
          held.tm.hour   = it.rtc_hour;
          held.tm.minute = it.rtc_minute;
          held.tm.second = it.rtc_second;
          held.tm.day    = it.rtc_day;
          held.tm.month  = it.rtc_month;
          held.tm.year   = it.rtc_year;
          if (held.last_second != held.tm.second) begin
            held.last_second = held.tm.second;
            held.same_count  = '0;
          end else if (held.same_count != CountMax) begin
            held.same_count = held.same_count + 8'd1;
          end
          if (held.tm.hour == held.tm.alarm_hour &&
              held.tm.minute == held.tm.alarm_minute &&
              held.tm.second < AlarmSecs) begin
            r.beep = 1'b1;
          end else if (held.tm.minute == '0 && held.tm.second == '0 &&
                       (held.same_count == 8'd0 || held.same_count == 8'd4)) begin
            r.beep = 1'b1;
          end
        end
      end
    endcase
    r.mode = held.mode;
    r.tm   = held.tm;
    return r;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Compare results first, then log the command taken at the same edge
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    ccs_item_t   it;
    ccs_result_t got;
    ccs_result_t want;
    if (!rst_ni) begin
      held.mode            = MODE_RUN;
      held.tm.hour         = '0;
      held.tm.minute       = '0;
      held.tm.second       = '0;
      held.tm.day          = 5'd1;
      held.tm.month        = 4'd1;
      held.tm.year         = '0;
      held.tm.alarm_hour   = '0;
      held.tm.alarm_minute = '0;
      held.last_second     = '0;
      held.same_count      = '0;
      predicted_readout_q.delete();
    end else begin
      if (out_i.valid && out_i.ready) begin
        got.mode            = out_i.edit_mode;
        got.tm.hour         = out_i.hour_out;
        got.tm.minute       = out_i.minute_out;
        got.tm.second       = out_i.second_out;
        got.tm.day          = out_i.day_out;
        got.tm.month        = out_i.month_out;
        got.tm.year         = out_i.year_out;
        got.tm.alarm_hour   = out_i.alarm_hour_out;
        got.tm.alarm_minute = out_i.alarm_minute_out;
        got.write_back      = out_i.write_back;
        got.beep            = out_i.beep;
        results++;
        if (got.beep === 1'b1) beeps++;
        if (got.write_back === 1'b1) write_backs++;
        if (predicted_readout_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none, got mode %0d %0d:%0d:%0d",
                   $time, got.mode, got.tm.hour, got.tm.minute, got.tm.second);
        end else begin
          want = predicted_readout_q.pop_front();
          check_field("edit_mode", want.mode, got.mode);
          check_field("hour_out", want.tm.hour, got.tm.hour);
          check_field("minute_out", want.tm.minute, got.tm.minute);
          check_field("second_out", want.tm.second, got.tm.second);
          check_field("day_out", want.tm.day, got.tm.day);
          check_field("month_out", want.tm.month, got.tm.month);
          check_field("year_out", want.tm.year, got.tm.year);
          check_field("alarm_hour_out", want.tm.alarm_hour, got.tm.alarm_hour);
          check_field("alarm_minute_out", want.tm.alarm_minute, got.tm.alarm_minute);
          check_field("write_back", want.write_back, got.write_back);
          check_field("beep", want.beep, got.beep);
        end
      end
      if (in_i.valid && in_i.ready) begin
        it.cmd        = in_i.cmd;
        it.rtc_hour   = in_i.rtc_hour;
        it.rtc_minute = in_i.rtc_minute;
        it.rtc_second = in_i.rtc_second;
        it.rtc_day    = in_i.rtc_day;
        it.rtc_month  = in_i.rtc_month;
        it.rtc_year   = in_i.rtc_year;
        predicted_readout_q.push_back(step_calendar(it));
      end
    end
    pending = predicted_readout_q.size();
  end

endmodule

// ===== dv/clock_calendar_setter_tb.sv =====
`timescale 1ns / 100ps

// Stimulus and verdict for the clock/calendar editor; checking lives in the
// checker instance beside the block.
module clock_calendar_setter_tb;
  import ccs_pkg::*;

  localparam int RandomCmds  = 1400;
  localparam int CycleLimit  = 400000;
  localparam int HoldStart   = 400;
  localparam int HoldCycles  = 200;
  localparam int DrainCycles = 10;
  localparam int SatRepeats  = 270;

  logic clk;
  logic rst_n;

  ccs_in_if  in_if ();
  ccs_out_if out_if ();

  int errors, pending, results, beeps, write_backs;
  int unsigned cycles = 0;
  int cur_mode    = 0;
  int useful_cmds = 0;
  int total_cmds  = 0;
  int burst_left  = 1;

  clock_calendar_setter DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  clock_calendar_setter_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_i          (in_if),
    .out_i         (out_if),
    .errors_o      (errors),
    .pending_o     (pending),
    .results_o     (results),
    .beeps_o       (beeps),
    .write_backs_o (write_backs)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("clock_calendar_setter test failed");
      $finish;
    end
  end

  // Receiver: changing stall patterns plus one long hold-off
  initial begin : receiver
    int phase_left;
    int pattern;
    int ticks;
    out_if.ready = 1'b0;
    phase_left   = 0;
    pattern      = 0;
    ticks        = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      ticks++;
      if (ticks == HoldStart) begin
        // back-pressure long enough to fill the block and stall its input
        out_if.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
      end else begin
        if (phase_left == 0) begin
          pattern    = $urandom_range(0, 3);
          phase_left = $urandom_range(32, 256);
        end
        phase_left--;
        case (pattern)
          0:       out_if.ready <= 1'b1;
          1:       out_if.ready <= $urandom_range(0, 1);
          2:       out_if.ready <= ($urandom_range(0, 9) != 0);
          default: out_if.ready <= ((ticks % 8) < 3);
        endcase
      end
    end
  end

  // Drive one command, hold it until taken, then maybe idle between bursts
  task automatic offer(input ccs_item_t it);
    int gap;
    in_if.valid      <= 1'b1;
    in_if.cmd        <= it.cmd;
    in_if.rtc_hour   <= it.rtc_hour;
    in_if.rtc_minute <= it.rtc_minute;
    in_if.rtc_second <= it.rtc_second;
    in_if.rtc_day    <= it.rtc_day;
    in_if.rtc_month  <= it.rtc_month;
    in_if.rtc_year   <= it.rtc_year;
    do @(posedge clk); while (!in_if.ready);
    total_cmds++;
    if (it.cmd == CMD_MODE) begin
      useful_cmds++;
      cur_mode = (cur_mode + 1) % 9;
    end else if ((it.cmd == CMD_SAMPLE) == (cur_mode == MODE_RUN)) begin
      useful_cmds++;
    end
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
  endtask

  function automatic ccs_item_t sample_of(int h, int mi, int s, int d, int mo, int y);
    ccs_item_t it;
    it.cmd        = CMD_SAMPLE;
    it.rtc_hour   = h[HourW-1:0];
    it.rtc_minute = mi[MinW-1:0];
    it.rtc_second = s[SecW-1:0];
    it.rtc_day    = d[DayW-1:0];
    it.rtc_month  = mo[MonW-1:0];
    it.rtc_year   = y[YearW-1:0];
    return it;
  endfunction

  // Any command with random, full-width payload bits
  function automatic ccs_item_t noise_of(input logic [CmdW-1:0] c);
    ccs_item_t it;
    it            = sample_of($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    it.cmd        = c;
    return it;
  endfunction

  // Sample biased towards the alarm, the chime, month ends and February
  function automatic ccs_item_t random_sample();
    ccs_item_t it;
    int r;
    it.cmd = CMD_SAMPLE;
    r = $urandom_range(0, 9);
    it.rtc_hour   = HourW'((r == 0) ? 0 : (r == 1) ? 1 : (r == 2) ? 23 :
                           (r == 3) ? $urandom : $urandom_range(0, 23));
    r = $urandom_range(0, 9);
    it.rtc_minute = MinW'((r < 3) ? 0 : (r == 3) ? 59 : (r == 4) ? 1 :
                          (r == 5) ? $urandom : $urandom_range(0, 59));
    r = $urandom_range(0, 9);
    it.rtc_second = SecW'((r < 3) ? 0 : (r < 5) ? $urandom_range(0, 9) :
                          (r == 5) ? $urandom : $urandom_range(0, 59));
    r = $urandom_range(0, 9);
    it.rtc_day    = DayW'((r == 0) ? $urandom : (r < 4) ? $urandom_range(28, 31) :
                          $urandom_range(1, 31));
    r = $urandom_range(0, 9);
    it.rtc_month  = MonW'((r == 0) ? $urandom : (r < 3) ? 2 : $urandom_range(1, 12));
    r = $urandom_range(0, 9);
    it.rtc_year   = YearW'((r == 0) ? $urandom : $urandom_range(0, 99));
    return it;
  endfunction

  task automatic press(input logic [CmdW-1:0] c);
    offer(noise_of(c));
  endtask

  task automatic go_to_mode(input int m);
    while (cur_mode != m) press(CMD_MODE);
  endtask

  task automatic edit_burst(input int m, input int n);
    go_to_mode(m);
    repeat (n) press($urandom_range(0, 1) ? CMD_UP : CMD_DOWN);
  endtask

  // Stimulus
  initial begin : stimulus
    int kind;
    int n;
    ccs_item_t it;
    bit saturated;
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.cmd        = CMD_MODE;
    in_if.rtc_hour   = '0;
    in_if.rtc_minute = '0;
    in_if.rtc_second = '0;
    in_if.rtc_day    = '0;
    in_if.rtc_month  = '0;
    in_if.rtc_year   = '0;
    saturated        = 1'b0;
    burst_left       = $urandom_range(1, 30);
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: field extremes, alarm, chime on first and fifth repeat
    offer(sample_of(23, 59, 59, 31, 12, 99));
    offer(sample_of(0, 0, 5, 1, 1, 0));
    repeat (5) offer(sample_of(5, 0, 0, 2, 2, 0));
    offer(sample_of(31, 63, 63, 31, 15, 127));
    // up/down ignored in run mode
    press(CMD_UP);
    press(CMD_DOWN);
    // hour past its width, then below zero
    press(CMD_MODE);
    press(CMD_UP);
    press(CMD_DOWN);
    // minute, second, day, month, year, alarm hour and minute
    for (int m = MODE_MINUTE; m <= MODE_AMIN; m++) begin
      press(CMD_MODE);
      press((m == MODE_SECOND || m >= MODE_AHOUR) ? CMD_DOWN : CMD_UP);
    end
    // sample outside run mode is dropped
    offer(sample_of(12, 30, 30, 15, 6, 50));
    press(CMD_MODE);

    // Random: mostly edit sessions and sample runs, some noise
    useful_cmds = 0;
    while (useful_cmds < RandomCmds) begin
      kind = $urandom_range(0, 19);
      if (!saturated && useful_cmds > RandomCmds / 2) begin
        // same second sampled until the repeat counter saturates
        go_to_mode(MODE_RUN);
        it = random_sample();
        repeat (SatRepeats) offer(it);
        saturated = 1'b1;
      end else if (kind < 7) begin
        go_to_mode(MODE_RUN);
        it = random_sample();
        repeat ($urandom_range(1, 6)) begin
          offer(it);
          if ($urandom_range(0, 2) == 0) it = random_sample();
        end
      end else if (kind < 13) begin
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        edit_burst($urandom_range(MODE_HOUR, MODE_AMIN), n);
        if ($urandom_range(0, 1)) go_to_mode(MODE_RUN);
      end else if (kind < 15) begin
        if (cur_mode == MODE_RUN) press(CMD_MODE);
        offer(random_sample());
      end else if (kind < 17) begin
        repeat ($urandom_range(1, 4)) offer(noise_of(CmdW'($urandom)));
      end else begin
        // February around a leap year, then nudge the day or the year
        go_to_mode(MODE_RUN);
        offer(sample_of($urandom_range(0, 23), $urandom_range(0, 59),
                        $urandom_range(0, 59), $urandom_range(27, 30), 2,
                        $urandom_range(0, 99)));
        edit_burst($urandom_range(0, 1) ? MODE_DAY : MODE_YEAR, $urandom_range(1, 4));
        if ($urandom_range(0, 1)) edit_burst(MODE_DAY, $urandom_range(1, 3));
      end
    end

    in_if.valid <= 1'b0;
    wait (pending == 0);
    repeat (DrainCycles) @(negedge clk);

    $display("Run covered %0d commands in %0d cycles: %0d results checked,", total_cmds,
             cycles, results);
    $display("  %0d with a beep and %0d with a write-back request.", beeps, write_backs);
    if (errors == 0) begin
      $display("clock_calendar_setter test passed");
    end else begin
      $display("clock_calendar_setter test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/ccs_pkg.sv
sv/ccs_if.sv
sv/ccs_edit.sv
sv/ccs_datapath.sv
sv/clock_calendar_setter.sv
sv/ccs_checker.sv
dv/clock_calendar_setter_checker.sv
dv/clock_calendar_setter_tb.sv
